>>> rtl/core/vehicle_tractive_fault_fsm_top_macros.svh
// Assertion macros used by the tractive supervisor checker.
`ifndef VEHICLE_TRACTIVE_FAULT_FSM_TOP_MACROS_SVH
`define VEHICLE_TRACTIVE_FAULT_FSM_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define VTF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define VTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vtf_pkg.sv
// Types and constants of the tractive supervisor.
`default_nettype none
package vtf_pkg;

    localparam int MASK_W      = 32;
    localparam int GRACE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MODE_W      = 3;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t ST_OFF    = 3'd0;
    localparam mode_t ST_ON     = 3'd1;
    localparam mode_t ST_RUN    = 3'd2;
    localparam mode_t ST_MINOR  = 3'd3;
    localparam mode_t ST_SEVERE = 3'd4;

    localparam logic [2:0] LED_CYAN    = 3'd0;
    localparam logic [2:0] LED_MAGENTA = 3'd1;
    localparam logic [2:0] LED_GREEN   = 3'd2;
    localparam logic [2:0] LED_YELLOW  = 3'd3;
    localparam logic [2:0] LED_RED     = 3'd4;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ALWAYS_SEVERE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HV_VOLTAGE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HV_CURRENT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_APPS_PROP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TSAL_FAULT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OTHER_MINOR   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HV_GRACE      = 3'd6;

    localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd10000;

    typedef struct packed {
        logic [MASK_W-1:0]  always_severe;
        logic [MASK_W-1:0]  hv_voltage;
        logic [MASK_W-1:0]  hv_current;
        logic [MASK_W-1:0]  apps_prop;
        logic [MASK_W-1:0]  tsal_fault;
        logic [MASK_W-1:0]  other_minor;
        logic [GRACE_W-1:0] hv_grace;
    } cfg_t;

    typedef struct packed {
        logic [GRACE_W-1:0] count;
        logic               active;
        logic               expired;
    } timer_t;

    typedef struct packed {
        mode_t  mode;
        timer_t volt;
        timer_t curr;
    } sup_state_t;

    typedef struct packed {
        logic              operation;
        logic              tsal_on;
        logic              ready_to_drive;
        logic [MASK_W-1:0] fault_word;
    } item_t;

    typedef struct packed {
        logic [1:0] timers_running;
        logic [2:0] led_colour;
        mode_t      vehicle_state;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/core/vehicle_tractive_fault_fsm_top.sv
// Tractive supervisor: five-state fault machine with two HV grace timers.
// Each accepted item (a state step or a timer tick) yields exactly one result.
// An item waits in the input register; the transition logic then
// updates the supervisor state and loads the result register in the same
// edge, so a result passes through the input register and then the result
// register, and one item is taken every cycle when the output side keeps
// up. The input and result registers decouple the two sides: a new item
// is taken while an earlier result still waits. Configuration writes take
// effect on the next edge and must only be issued while the block is idle.
`default_nettype none
module vehicle_tractive_fault_fsm_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // operation
    input  logic                                 s_tuser,
    // tsal_on, ready_to_drive, fault_word[31:0], zero pad
    input  logic [vtf_pkg::IN_DATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // vehicle_state[2:0], led_colour[2:0], timers_running[1:0]
    output logic [vtf_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [vtf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [vtf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import vtf_pkg::*;

    cfg_t       cfg;
    item_t      in_reg;
    logic       in_valid_reg;
    sup_state_t sup_reg;
    sup_state_t sup_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_valid_reg;
    logic       advance;

    vtf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vtf_step u_step (
        .cfg        (cfg),
        .state_cur  (sup_reg),
        .item       (in_reg),
        .state_next (sup_next),
        .result     (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sup_reg.mode  <= ST_OFF;
            sup_reg.volt  <= '0;
            sup_reg.curr  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                sup_reg       <= sup_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.operation      <= s_tuser;
            in_reg.tsal_on        <= s_tdata[0];
            in_reg.ready_to_drive <= s_tdata[1];
            in_reg.fault_word     <= s_tdata[MASK_W+1:2];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

endmodule
`default_nettype wire

>>> rtl/core/vtf_cfg.sv
// Configuration register file: fault-group masks and HV grace length.
`default_nettype none
module vtf_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [vtf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vtf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output vtf_pkg::cfg_t                    cfg
);
    import vtf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.always_severe <= '0;
            cfg_reg.hv_voltage    <= '0;
            cfg_reg.hv_current    <= '0;
            cfg_reg.apps_prop     <= '0;
            cfg_reg.tsal_fault    <= '0;
            cfg_reg.other_minor   <= '0;
            cfg_reg.hv_grace      <= GRACE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALWAYS_SEVERE: cfg_reg.always_severe <= cfg_wdata;
                REG_HV_VOLTAGE:    cfg_reg.hv_voltage    <= cfg_wdata;
                REG_HV_CURRENT:    cfg_reg.hv_current    <= cfg_wdata;
                REG_APPS_PROP:     cfg_reg.apps_prop     <= cfg_wdata;
                REG_TSAL_FAULT:    cfg_reg.tsal_fault    <= cfg_wdata;
                REG_OTHER_MINOR:   cfg_reg.other_minor   <= cfg_wdata;
                REG_HV_GRACE:      cfg_reg.hv_grace      <= cfg_wdata[GRACE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/core/vtf_step.sv
// Transition logic: next supervisor state and result for one item.
`default_nettype none
module vtf_step (
    input  vtf_pkg::cfg_t       cfg,
    input  vtf_pkg::sup_state_t state_cur,
    input  vtf_pkg::item_t      item,
    output vtf_pkg::sup_state_t state_next,
    output vtf_pkg::result_t    result
);
    import vtf_pkg::*;

    function automatic timer_t tick_timer(input timer_t t);
        timer_t r;
        r = t;
        if (t.active) begin
            if (t.count <= GRACE_W'(1)) begin
                r.count   = '0;
                r.active  = 1'b0;
                r.expired = 1'b1;
            end else begin
                r.count = t.count - GRACE_W'(1);
            end
        end
        return r;
    endfunction

    function automatic timer_t start_timer(input timer_t t, input logic [GRACE_W-1:0] grace);
        timer_t r;
        r = t;
        if (!t.active) begin
            r.count   = grace;
            r.active  = 1'b1;
            r.expired = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [2:0] colour_of(input mode_t m);
        logic [2:0] c;
        case (m)
            ST_OFF:   c = LED_CYAN;
            ST_ON:    c = LED_MAGENTA;
            ST_RUN:   c = LED_GREEN;
            ST_MINOR: c = LED_YELLOW;
            default:  c = LED_RED;
        endcase
        return c;
    endfunction

    logic fault_any;
    logic hit_always, hit_volt, hit_curr, hit_apps, hit_tsal, hit_other;
    logic sev_volt, sev_curr, severe, clr_volt, clr_curr;
    logic tsal, rtd;
    sup_state_t nxt;

    always_comb begin
        tsal       = item.tsal_on;
        rtd        = item.ready_to_drive;
        fault_any  = |item.fault_word;
        hit_always = |(item.fault_word & cfg.always_severe);
        hit_volt   = |(item.fault_word & cfg.hv_voltage);
        hit_curr   = |(item.fault_word & cfg.hv_current);
        hit_apps   = |(item.fault_word & cfg.apps_prop);
        hit_tsal   = |(item.fault_word & cfg.tsal_fault);
        hit_other  = |(item.fault_word & cfg.other_minor);
        sev_volt   = hit_volt && state_cur.volt.expired;
        sev_curr   = hit_curr && state_cur.curr.expired;
        severe     = hit_always || sev_volt || sev_curr
                     || (hit_apps && state_cur.mode == ST_RUN)
                     || (hit_tsal && (state_cur.mode == ST_RUN || state_cur.mode == ST_ON));
        clr_volt   = !hit_always && sev_volt;
        clr_curr   = !hit_always && !sev_volt && sev_curr;

        nxt = state_cur;
        if (item.operation == OP_TICK) begin
            nxt.volt = tick_timer(state_cur.volt);
            nxt.curr = tick_timer(state_cur.curr);
        end else begin
            case (state_cur.mode)
                ST_OFF: begin
                    if (rtd || fault_any) begin
                        nxt.mode = ST_SEVERE;
                    end else if (tsal) begin
                        nxt.mode = ST_ON;
                    end
                end
                ST_ON, ST_RUN: begin
                    if (fault_any) begin
                        if (clr_volt) nxt.volt.expired = 1'b0;
                        if (clr_curr) nxt.curr.expired = 1'b0;
                        if (severe) begin
                            nxt.mode = ST_SEVERE;
                        end else if (hit_volt) begin
                            nxt.volt = start_timer(state_cur.volt, cfg.hv_grace);
                            nxt.mode = ST_MINOR;
                        end else if (hit_curr) begin
                            nxt.curr = start_timer(state_cur.curr, cfg.hv_grace);
                            nxt.mode = ST_MINOR;
                        end else if (hit_other) begin
                            nxt.mode = ST_MINOR;
                        end
                    end else if (state_cur.mode == ST_ON) begin
                        if (!tsal) begin
                            nxt.mode = ST_OFF;
                        end else if (rtd) begin
                            nxt.mode = ST_RUN;
                        end
                    end else begin
                        if (!tsal) begin
                            nxt.mode = ST_SEVERE;
                        end else if (!rtd) begin
                            nxt.mode = ST_ON;
                        end
                    end
                end
                ST_MINOR: begin
                    if (fault_any) begin
                        if (clr_volt) nxt.volt.expired = 1'b0;
                        if (clr_curr) nxt.curr.expired = 1'b0;
                    end
                    if (fault_any && severe) begin
                        nxt.mode = ST_SEVERE;
                    end else if (rtd && tsal) begin
                        nxt.mode = ST_RUN;
                    end else if (!rtd && tsal) begin
                        nxt.mode = ST_ON;
                    end else if (!rtd) begin
                        nxt.mode = ST_OFF;
                    end
                    // stop both timers on exit, keep expired flags
                    if (nxt.mode != ST_MINOR) begin
                        nxt.volt.count  = '0;
                        nxt.volt.active = 1'b0;
                        nxt.curr.count  = '0;
                        nxt.curr.active = 1'b0;
                    end
                end
                ST_SEVERE: begin
                    if (!fault_any && !rtd) begin
                        nxt.mode = ST_OFF;
                    end
                end
                default: begin
                    nxt.mode = ST_SEVERE;
                end
            endcase
        end

        state_next            = nxt;
        result.vehicle_state  = nxt.mode;
        result.led_colour     = colour_of(state_cur.mode);
        result.timers_running = {nxt.curr.active, nxt.volt.active};
    end

endmodule
`default_nettype wire

>>> rtl/core/vtf_checker.sv
// Port-level checker for the tractive supervisor, bound to the top level.
`default_nettype none
`include "vehicle_tractive_fault_fsm_top_macros.svh"
module vtf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [vtf_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import vtf_pkg::*;

    mode_t last_state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_state_reg <= ST_OFF;
        end else if (m_tvalid && m_tready) begin
            last_state_reg <= m_tdata[2:0];
        end
    end

    `VTF_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result item changed")
    `VTF_ASSERT_IMPLIES(a_codes_valid, m_tvalid, m_tdata[2:0] <= ST_SEVERE && m_tdata[5:3] <= LED_RED, "state or colour code out of range")
    `VTF_ASSERT_IMPLIES(a_led_chain, m_tvalid, m_tdata[5:3] == last_state_reg, "colour does not match previous state")
    `VTF_ASSERT_IMPLIES(a_timers_minor, m_tvalid && m_tdata[7:6] != 2'b00, m_tdata[2:0] == ST_MINOR, "grace timer running outside minor fault")

endmodule

bind vehicle_tractive_fault_fsm_top vtf_checker u_vtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> tb/tb_vehicle_tractive_fault_fsm_top.sv
// Self-checking testbench of the tractive supervisor with random stalls on both streams.
`timescale 1ns / 1ps
module tb_vehicle_tractive_fault_fsm_top;
    import vtf_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned SETTINGS_RUN = 6;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic                   s_tuser = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    vehicle_tractive_fault_fsm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    item_t       pending_items[$];
    result_t     expected_results[$];
    int unsigned mismatches = 0;

    cfg_t        cfg_shadow;
    mode_t       sup_mode;
    timer_t      volt_tmr;
    timer_t      curr_tmr;
    logic [31:0] next_masks [6];

    item_t       next_item;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    logic        src_calm = 1'b0;
    logic        sink_calm = 1'b0;
    int unsigned quiet_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [2:0] led_of(mode_t m);
        case (m)
            ST_OFF:   return LED_CYAN;
            ST_ON:    return LED_MAGENTA;
            ST_RUN:   return LED_GREEN;
            ST_MINOR: return LED_YELLOW;
            default:  return LED_RED;
        endcase
    endfunction

    function automatic timer_t count_down(timer_t t);
        if (t.active) begin
            if (t.count <= 1) begin
                t.count = '0;
                t.active = 1'b0;
                t.expired = 1'b1;
            end else begin
                t.count = t.count - 1'b1;
            end
        end
        return t;
    endfunction

    function automatic logic severe_hit(logic [31:0] f, mode_t st);
        if (f == 0) return 1'b0;
        if ((f & cfg_shadow.always_severe) != 0) return 1'b1;
        if ((f & cfg_shadow.hv_voltage) != 0 && volt_tmr.expired) begin
            volt_tmr.expired = 1'b0;
            return 1'b1;
        end
        if ((f & cfg_shadow.hv_current) != 0 && curr_tmr.expired) begin
            curr_tmr.expired = 1'b0;
            return 1'b1;
        end
        if ((f & cfg_shadow.apps_prop) != 0 && st == ST_RUN) return 1'b1;
        if ((f & cfg_shadow.tsal_fault) != 0 && (st == ST_RUN || st == ST_ON)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic minor_hit(logic [31:0] f);
        if (f == 0) return 1'b0;
        if ((f & cfg_shadow.hv_voltage) != 0) begin
            if (!volt_tmr.active) begin
                volt_tmr.expired = 1'b0;
                volt_tmr.active = 1'b1;
                volt_tmr.count = cfg_shadow.hv_grace;
            end
            return 1'b1;
        end
        if ((f & cfg_shadow.hv_current) != 0) begin
            if (!curr_tmr.active) begin
                curr_tmr.expired = 1'b0;
                curr_tmr.active = 1'b1;
                curr_tmr.count = cfg_shadow.hv_grace;
            end
            return 1'b1;
        end
        return (f & cfg_shadow.other_minor) != 0;
    endfunction

    function automatic mode_t classify_fault(logic [31:0] f, mode_t st);
        if (severe_hit(f, st)) return ST_SEVERE;
        if (minor_hit(f)) return ST_MINOR;
        return st;
    endfunction

    function automatic result_t supervise_item(logic op, logic tsal, logic rtd,
                                               logic [31:0] f);
        mode_t   prior;
        mode_t   nxt;
        result_t r;
        prior = sup_mode;
        nxt = prior;
        if (op == OP_TICK) begin
            volt_tmr = count_down(volt_tmr);
            curr_tmr = count_down(curr_tmr);
        end else begin
            case (prior)
                ST_OFF: begin
                    if (rtd || f != 0) nxt = ST_SEVERE;
                    else if (tsal) nxt = ST_ON;
                end
                ST_ON: begin
                    if (f != 0) nxt = classify_fault(f, prior);
                    else if (!tsal) nxt = ST_OFF;
                    else if (rtd) nxt = ST_RUN;
                end
                ST_RUN: begin
                    if (f != 0) nxt = classify_fault(f, prior);
                    else if (!tsal) nxt = ST_SEVERE;
                    else if (!rtd) nxt = ST_ON;
                end
                ST_MINOR: begin
                    if (f != 0 && severe_hit(f, prior)) nxt = ST_SEVERE;
                    else if (rtd && tsal) nxt = ST_RUN;
                    else if (!rtd && tsal) nxt = ST_ON;
                    else if (!rtd) nxt = ST_OFF;
                    if (nxt != ST_MINOR) begin
                        volt_tmr.active = 1'b0;
                        volt_tmr.count = '0;
                        curr_tmr.active = 1'b0;
                        curr_tmr.count = '0;
                    end
                end
                ST_SEVERE: begin
                    if (f == 0 && !rtd) nxt = ST_OFF;
                end
                default: nxt = ST_SEVERE;
            endcase
            sup_mode = nxt;
        end
        r.vehicle_state = sup_mode;
        r.led_colour = led_of(prior);
        r.timers_running = {curr_tmr.active, volt_tmr.active};
        return r;
    endfunction

    function automatic int unsigned pick_wait(logic calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [31:0] draw_fault();
        logic [31:0] pick;
        logic [31:0] sub;
        case ($urandom_range(0, 11))
            0, 1, 2, 3: return '0;
            4: pick = cfg_shadow.always_severe;
            5: pick = cfg_shadow.hv_voltage;
            6: pick = cfg_shadow.hv_current;
            7: pick = cfg_shadow.apps_prop;
            8: pick = cfg_shadow.tsal_fault;
            9: pick = cfg_shadow.other_minor;
            10: return $urandom();
            default: return '1;
        endcase
        sub = pick & $urandom();
        return (sub != 0) ? sub : pick;
    endfunction

    task automatic push_step(logic tsal, logic rtd, logic [31:0] f);
        pending_items.push_back(item_t'({OP_STEP, tsal, rtd, f}));
    endtask

    task automatic push_tick();
        pending_items.push_back(item_t'({OP_TICK, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), 32'($urandom())}));
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ALWAYS_SEVERE: cfg_shadow.always_severe = val;
            REG_HV_VOLTAGE:    cfg_shadow.hv_voltage = val;
            REG_HV_CURRENT:    cfg_shadow.hv_current = val;
            REG_APPS_PROP:     cfg_shadow.apps_prop = val;
            REG_TSAL_FAULT:    cfg_shadow.tsal_fault = val;
            REG_OTHER_MINOR:   cfg_shadow.other_minor = val;
            REG_HV_GRACE:      cfg_shadow.hv_grace = val[GRACE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [15:0] grace);
        write_reg(REG_ALWAYS_SEVERE, next_masks[0]);
        write_reg(REG_HV_VOLTAGE, next_masks[1]);
        write_reg(REG_HV_CURRENT, next_masks[2]);
        write_reg(REG_APPS_PROP, next_masks[3]);
        write_reg(REG_TSAL_FAULT, next_masks[4]);
        write_reg(REG_OTHER_MINOR, next_masks[5]);
        write_reg(REG_HV_GRACE, {16'($urandom()), grace});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(int unsigned kind);
        int unsigned g;
        for (int i = 0; i < 6; i++) next_masks[i] = '0;
        if (kind == 1) begin
            for (int i = 0; i < 6; i++) next_masks[i] = '1;
            load_setting(16'd0);
        end else if (kind == 3) begin
            next_masks[1] = $urandom();
            next_masks[2] = next_masks[1] | 32'($urandom());
            next_masks[5] = $urandom();
            load_setting(16'd1);
        end else if (kind == 4) begin
            for (int i = 0; i < 6; i++) next_masks[i] = $urandom() & $urandom() & $urandom();
            load_setting(16'($urandom_range(1, 6)));
        end else begin
            for (int b = 0; b < 32; b++) begin
                g = $urandom_range(0, 6);
                if (g < 6) next_masks[g][b] = 1'b1;
            end
            case (kind)
                0:       load_setting(16'($urandom_range(0, 4)));
                2:       load_setting(16'hFFFF);
                default: load_setting(16'd3);
            endcase
        end
    endtask

    task automatic random_part(int unsigned target);
        int unsigned made;
        int unsigned run_len;
        int unsigned pick;
        logic [31:0] hv;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                push_step(1'b0, 1'b0, '0);
                push_step(1'b0, 1'b0, '0);
                push_step(1'b1, 1'b0, '0);
                push_step(1'b1, 1'b1, '0);
                made += 4;
            end
            if (pick < 11) begin
                run_len = $urandom_range(3, 14);
                repeat (run_len) begin
                    if ($urandom_range(0, 9) < 4) push_tick();
                    else push_step($urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0,
                                   draw_fault());
                end
                made += run_len;
            end else if (pick < 15) begin
                hv = $urandom_range(0, 1) ? cfg_shadow.hv_voltage : cfg_shadow.hv_current;
                hv = ((hv & $urandom()) != 0) ? (hv & $urandom()) : hv;
                push_step(1'b1, 1'($urandom_range(0, 1)), hv);
                run_len = (cfg_shadow.hv_grace > 12) ? 12 : cfg_shadow.hv_grace;
                run_len = run_len + $urandom_range(0, 2);
                run_len = (run_len > 0) ? run_len - 1 : 0;
                repeat (run_len) push_tick();
                push_step($urandom_range(0, 2) != 0 ? 1'b0 : 1'b1, $urandom_range(0, 3) != 0,
                          $urandom_range(0, 4) != 0 ? hv : draw_fault());
                made += run_len + 2;
            end else begin
                repeat (6) begin
                    if ($urandom_range(0, 3) == 0) push_tick();
                    else push_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   draw_fault());
                end
                made += 6;
            end
        end
    endtask

    task automatic compare_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(supervise_item(s_tuser, s_tdata[0], s_tdata[1],
                                                          s_tdata[33:2]));
                if ($urandom_range(0, 39) == 0) src_calm <= ~src_calm;
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait != 0) begin
                    s_tvalid <= 1'b0;
                    src_wait <= src_wait - 1;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_item.operation;
                    s_tdata <= {6'd0, next_item.fault_word, next_item.ready_to_drive,
                                next_item.tsal_on};
                    src_wait <= pick_wait(src_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t     want;
        result_t     got;
        int unsigned hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end else begin
                want = expected_results.pop_front();
                compare_field("vehicle_state", want.vehicle_state, got.vehicle_state);
                compare_field("led_colour", want.led_colour, got.led_colour);
                compare_field("timers_running", want.timers_running, got.timers_running);
            end
            hold = pick_wait(sink_calm);
            sink_wait <= hold;
            m_tready <= (hold == 0);
            if ($urandom_range(0, 39) == 0) sink_calm <= ~sink_calm;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_tready <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_shadow = '0;
        cfg_shadow.hv_grace = GRACE_RESET;
        sup_mode = ST_OFF;
        volt_tmr = '0;
        curr_tmr = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        push_step(1'b0, 1'b0, '0);
        push_tick();
        push_step(1'b1, 1'b0, '0);
        push_step(1'b1, 1'b0, 32'h8000_0000);
        push_step(1'b1, 1'b1, '0);
        push_step(1'b1, 1'b1, 32'hFFFF_FFFF);
        push_step(1'b0, 1'b1, '0);
        push_step(1'b0, 1'b1, '0);
        push_step(1'b0, 1'b0, '0);
        push_step(1'b0, 1'b1, '0);
        push_step(1'b0, 1'b0, '0);
        push_step(1'b1, 1'b0, 32'h0000_0001);
        push_step(1'b0, 1'b0, '0);
        wait_idle();

        next_masks = '{32'h01, 32'h02, 32'h04, 32'h08, 32'h10, 32'h20};
        load_setting(16'd2);
        push_step(1'b1, 1'b0, '0);
        push_step(1'b1, 1'b0, 32'h02);
        push_tick();
        push_tick();
        push_step(1'b0, 1'b1, 32'h02);
        push_step(1'b0, 1'b0, '0);
        push_step(1'b1, 1'b0, '0);
        push_step(1'b1, 1'b0, 32'h10);
        push_step(1'b0, 1'b0, '0);
        push_step(1'b1, 1'b0, '0);
        push_step(1'b1, 1'b1, '0);
        push_step(1'b1, 1'b1, 32'h08);

        for (int unsigned k = 0; k < SETTINGS_RUN; k++) begin
            wait_idle();
            apply_setting(k);
            random_part(RANDOM_ITEMS / SETTINGS_RUN);
        end
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
